### hw/rtl/fccf_pkg.sv
package fccf_pkg;

    // Row buffer geometry
    localparam int MAX_GROUP_ROWS = 32;
    localparam int ADDR_W = (MAX_GROUP_ROWS > 1) ? $clog2(MAX_GROUP_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_GROUP_ROWS + 1);

    // Field widths
    localparam int FRAME_W = 32;
    localparam int POS_W = 12;
    localparam int BRIGHT_W = 16;
    localparam int CHARGE_W = 4;
    localparam int FILE_W = 16;
    localparam int TARGET_W = 6;

    // Charges that are counted
    localparam int NUM_CHARGES = 4;
    localparam logic [CHARGE_W-1:0] CHARGE_LOW = 4'd1;
    localparam logic [CHARGE_W-1:0] CHARGE_HIGH = 4'd4;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TWO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FOUR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_NUMBER = 3'd4;
    localparam logic [FILE_W-1:0] FILE_NUMBER_RESET = 16'd1;

    // One buffered row; the frame is common to the group and kept apart
    typedef struct packed {
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [BRIGHT_W-1:0] brightness;
        logic [CHARGE_W-1:0] charge;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_ADD,
        ST_JUDGE
    } state_t;

endpackage

### hw/rtl/fccf_ram.sv
// Simple dual-port RAM, registered read data
module fccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/frame_charge_combination_filter.sv
// A row that closes nothing is taken in ST_IDLE; one flagged end_of_list also passes
// through ST_JUDGE. Each emitted row takes a row buffer read (ST_READ), then an output
// register load (ST_EMIT) that waits for a free output slot; a new frame closing a match
// adds ST_ADD for the held row. The input is ready only in ST_IDLE and waits while a
// matching group drains. Reset clears control, counters, config and out_valid; the
// held row, the row buffer and the output payload are not cleared.
module frame_charge_combination_filter
    import fccf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FRAME_W-1:0]    frame_number,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic [BRIGHT_W-1:0]   brightness,
    input  logic [CHARGE_W-1:0]   charge_state,
    input  logic                  end_of_list,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FILE_W-1:0]     out_file_number,
    output logic [FRAME_W-1:0]    out_frame,
    output logic [POS_W-1:0]      out_x,
    output logic [POS_W-1:0]      out_y,
    output logic [BRIGHT_W-1:0]   out_brightness,
    output logic [CHARGE_W-1:0]   out_charge,
    output logic                  last_of_run
);

    // Configuration registers
    logic [TARGET_W-1:0] target_reg [NUM_CHARGES];
    logic [FILE_W-1:0]   file_number_reg;

    // Sequencer
    state_t state_reg, state_next;
    logic   drain_old_reg, drain_old_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;

    // Held input row
    row_t                row_reg;
    logic [FRAME_W-1:0]  row_frame_reg;
    logic                last_in_reg;

    // Open group state
    logic [FRAME_W-1:0]  group_frame_reg, group_frame_next;
    logic [CNT_W-1:0]    group_count_reg, group_count_next;
    logic                group_open_reg, group_open_next;
    logic [CNT_W-1:0]    charge_cnt_reg [NUM_CHARGES];
    logic [CNT_W-1:0]    charge_cnt_next [NUM_CHARGES];
    logic                foreign_reg, foreign_next;
    logic                overflow_reg, overflow_next;

    // Output register
    logic                out_valid_reg;
    row_t                out_row_reg;
    logic [FILE_W-1:0]   out_file_reg;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic                out_last_reg;

    // Control and datapath signals
    logic                in_xfer;
    logic                close_old;
    logic                match_cur;
    logic                single_match;
    logic                slot_free;
    logic                drain_final;
    logic                emit_load;
    logic                clear_grp;
    logic                add_en;
    logic                add_clear;
    row_t                add_row;
    logic [FRAME_W-1:0]  add_frame;
    logic                add_in_range;
    logic [1:0]          add_idx;
    logic [CNT_W-1:0]    base_count;
    logic                mem_we;
    logic                mem_re;
    row_t                mem_rdata;
    row_t                in_row;
    logic                row_in_range;
    logic [1:0]          row_idx;

    assign in_row = '{x: pos_x, y: pos_y, brightness: brightness, charge: charge_state};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHARGES; i++)
            begin
                target_reg[i] <= '0;
            end
            file_number_reg <= FILE_NUMBER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_ONE:   target_reg[0] <= cfg_data[TARGET_W-1:0];
                REG_TARGET_TWO:   target_reg[1] <= cfg_data[TARGET_W-1:0];
                REG_TARGET_THREE: target_reg[2] <= cfg_data[TARGET_W-1:0];
                REG_TARGET_FOUR:  target_reg[3] <= cfg_data[TARGET_W-1:0];
                REG_FILE_NUMBER:  file_number_reg <= cfg_data[FILE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Group judgement against the target multiset
    always_comb
    begin
        match_cur = group_open_reg && !foreign_reg && !overflow_reg;
        for (int i = 0; i < NUM_CHARGES; i++)
        begin
            if (TARGET_W'(charge_cnt_reg[i]) != target_reg[i])
            begin
                match_cur = 1'b0;
            end
        end
    end

    // Would the held row alone, as a one-row group, match
    assign row_in_range = (row_reg.charge >= CHARGE_LOW) && (row_reg.charge <= CHARGE_HIGH);
    assign row_idx = 2'(row_reg.charge - CHARGE_LOW);

    always_comb
    begin
        single_match = row_in_range;
        for (int i = 0; i < NUM_CHARGES; i++)
        begin
            if (target_reg[i] != ((2'(i) == row_idx) ? TARGET_W'(1) : TARGET_W'(0)))
            begin
                single_match = 1'b0;
            end
        end
    end

    assign in_xfer = in_valid && in_ready;
    assign close_old = group_open_reg && (frame_number != group_frame_reg);
    assign slot_free = !out_valid_reg || out_ready;
    assign drain_final = (CNT_W'(rd_cnt_reg + 1'b1) == group_count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (close_old && match_cur)
                    begin
                        state_next = ST_READ;
                    end
                    else if (end_of_list)
                    begin
                        state_next = ST_JUDGE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    if (!drain_final)
                    begin
                        state_next = ST_READ;
                    end
                    else if (drain_old_reg)
                    begin
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ADD:
            begin
                state_next = last_in_reg ? ST_JUDGE : ST_IDLE;
            end
            ST_JUDGE:
            begin
                state_next = match_cur ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        mem_re = 1'b0;
        emit_load = 1'b0;
        clear_grp = 1'b0;
        add_en = 1'b0;
        add_clear = 1'b0;
        add_row = in_row;
        add_frame = frame_number;
        drain_old_next = drain_old_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_cnt_next = '0;
                drain_old_next = 1'b1;
                add_en = in_xfer && !(close_old && match_cur);
                add_clear = close_old;
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_EMIT:
            begin
                emit_load = slot_free;
                if (slot_free)
                begin
                    rd_cnt_next = CNT_W'(rd_cnt_reg + 1'b1);
                    clear_grp = drain_final && !drain_old_reg;
                end
            end
            ST_ADD:
            begin
                add_en = 1'b1;
                add_clear = 1'b1;
                add_row = row_reg;
                add_frame = row_frame_reg;
            end
            ST_JUDGE:
            begin
                rd_cnt_next = '0;
                drain_old_next = 1'b0;
                clear_grp = !match_cur;
            end
            default:
            begin
            end
        endcase
    end

    // Group update: clear on close, or take in one row
    assign add_in_range = (add_row.charge >= CHARGE_LOW) && (add_row.charge <= CHARGE_HIGH);
    assign add_idx = 2'(add_row.charge - CHARGE_LOW);
    assign base_count = add_clear ? '0 : group_count_reg;
    assign mem_we = add_en && (base_count < CNT_W'(MAX_GROUP_ROWS));

    always_comb
    begin
        group_frame_next = group_frame_reg;
        group_count_next = group_count_reg;
        group_open_next = group_open_reg;
        foreign_next = foreign_reg;
        overflow_next = overflow_reg;
        for (int i = 0; i < NUM_CHARGES; i++)
        begin
            charge_cnt_next[i] = charge_cnt_reg[i];
        end
        if (clear_grp)
        begin
            group_count_next = '0;
            group_open_next = 1'b0;
            foreign_next = 1'b0;
            overflow_next = 1'b0;
            for (int i = 0; i < NUM_CHARGES; i++)
            begin
                charge_cnt_next[i] = '0;
            end
        end
        else if (add_en)
        begin
            if (add_clear)
            begin
                foreign_next = 1'b0;
                overflow_next = 1'b0;
                for (int i = 0; i < NUM_CHARGES; i++)
                begin
                    charge_cnt_next[i] = '0;
                end
            end
            if (add_clear || !group_open_reg)
            begin
                group_frame_next = add_frame;
            end
            group_open_next = 1'b1;
            group_count_next = base_count;
            if (!mem_we)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                group_count_next = CNT_W'(base_count + 1'b1);
                if (add_in_range)
                begin
                    charge_cnt_next[add_idx] = CNT_W'(charge_cnt_next[add_idx] + 1'b1);
                end
                else
                begin
                    foreign_next = 1'b1;
                end
            end
        end
    end

    // Row buffer
    fccf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_GROUP_ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (base_count[ADDR_W-1:0]),
        .wdata (add_row),
        .re    (mem_re),
        .raddr (rd_cnt_reg[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    // Control and group state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_old_reg <= 1'b0;
            rd_cnt_reg <= '0;
            group_frame_reg <= '0;
            group_count_reg <= '0;
            group_open_reg <= 1'b0;
            foreign_reg <= 1'b0;
            overflow_reg <= 1'b0;
            for (int i = 0; i < NUM_CHARGES; i++)
            begin
                charge_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            drain_old_reg <= drain_old_next;
            rd_cnt_reg <= rd_cnt_next;
            group_frame_reg <= group_frame_next;
            group_count_reg <= group_count_next;
            group_open_reg <= group_open_next;
            foreign_reg <= foreign_next;
            overflow_reg <= overflow_next;
            for (int i = 0; i < NUM_CHARGES; i++)
            begin
                charge_cnt_reg[i] <= charge_cnt_next[i];
            end
        end
    end

    // Held copy of the accepted row
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            row_reg <= in_row;
            row_frame_reg <= frame_number;
            last_in_reg <= end_of_list;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload; the old group's last row is final only if
    // the held row will not go out as a one-row group after it
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_row_reg <= mem_rdata;
            out_file_reg <= file_number_reg;
            out_frame_reg <= group_frame_reg;
            out_last_reg <= drain_final && !(drain_old_reg && last_in_reg && single_match);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_file_number = out_file_reg;
    assign out_frame = out_frame_reg;
    assign out_x = out_row_reg.x;
    assign out_y = out_row_reg.y;
    assign out_brightness = out_row_reg.brightness;
    assign out_charge = out_row_reg.charge;
    assign last_of_run = out_last_reg;

endmodule
